// ===== rtl/ssp_pkg.sv =====
package ssp_pkg;

    // Field widths fixed by the item formats
    localparam int CAP_W   = 9;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd2;
    localparam logic [VAL_W-1:0] INT_MIN   = 32'h8000_0000;

    // Request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_POP_AT = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        [1:0]       req_type;
        logic signed [VAL_W-1:0] push_value;
        logic        [IDX_W-1:0] stack_index;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]   pop_value;
        logic        [1:0]         status;
        logic        [COUNT_W-1:0] element_count;
        logic        [COUNT_W-1:0] substack_count;
    } t_out_item;

endpackage

// ===== rtl/ssp_ram.sv =====
module ssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ssp_div.sv =====
module ssp_div #(
    parameter int NUM_W = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [ssp_pkg::CAP_W-1:0] i_den,
    output logic                      o_busy,
    output logic [NUM_W-1:0]          o_quot
);

    localparam int DEN_W = ssp_pkg::CAP_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;

    logic [DEN_W:0]    w_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // Shared subtract-and-compare: one quotient bit per cycle
    assign w_sh   = {r_rem, r_num[NUM_W-1]};
    assign w_ge   = (w_sh >= {1'b0, i_den});
    assign w_diff = w_sh - {1'b0, i_den};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift the dividend out and the quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

// ===== rtl/segmented_stack_with_pop_at.sv =====
// Segmented stack with pop-at. The contents are one flat stack, split into
// sub-stacks of plate_capacity entries (a capacity of zero acts as one).
// One request is handled at a time: input ready is low from the accepted
// transfer until the result is loaded into the output register, and a
// finished result may wait there while the next request is taken. After
// every change of the contents, and after every capacity write, the
// sub-stack count is recomputed by a bit-serial divider that runs NUM_W
// steps (NUM_W = max(clog2(DEPTH+1), 9) + 1, so 10 at DEPTH 256). A push,
// a pop and a capacity write each wait until the divider is done; an error
// or unused code skips it. A pop at an inner sub-stack also moves every
// later entry down one slot through the single read/write port pair of the
// entry memory, one read and one write per entry. A result that cannot
// leave the output register holds the block until it is taken.
module segmented_stack_with_pop_at #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  ssp_pkg::t_in_item         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output ssp_pkg::t_out_item        o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ssp_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int CAP_W  = ssp_pkg::CAP_W;
    localparam int VAL_W  = ssp_pkg::VAL_W;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > ssp_pkg::IDX_W ? CNT_W : ssp_pkg::IDX_W) + 1;
    localparam int NUM_W  = (CNT_W > CAP_W ? CNT_W : CAP_W) + 1;
    localparam int PROD_W = 2 * CAP_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_RD      = 4'd2;
    localparam logic [3:0] S_CAP     = 4'd3;
    localparam logic [3:0] S_SH_RD   = 4'd4;
    localparam logic [3:0] S_SH_WR   = 4'd5;
    localparam logic [3:0] S_DIV_SET = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]                r_state;
    logic [CAP_W-1:0]          r_cap;
    logic [CNT_W-1:0]          r_total;
    logic [CNT_W-1:0]          r_sub;
    logic                      r_from_cfg;
    logic [ssp_pkg::IDX_W-1:0] r_idx;
    logic [ADDR_W-1:0]         r_ptr;
    logic [VAL_W-1:0]          r_val;
    logic [1:0]                r_status;
    logic                      r_out_valid;
    ssp_pkg::t_out_item        r_out;

    logic [CAP_W-1:0]          w_ceff;
    logic                      w_full;
    logic [CMP_W-1:0]          w_idx_c;
    logic [CMP_W-1:0]          w_sub_c;
    logic [CMP_W-1:0]          w_total_c;
    logic [CMP_W-1:0]          w_ptr_c;
    logic                      w_idx_last;
    logic                      w_idx_bad;
    logic                      w_in_xfer;
    logic                      w_cfg_xfer;
    logic                      w_out_load;
    logic [PROD_W-1:0]         w_prod;

    logic signed [63:0]           w_push64;
    logic signed [DATA_WIDTH-1:0] w_rd_s;
    logic signed [63:0]           w_rd64;

    logic                      w_we;
    logic [ADDR_W-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0]     w_wdata;
    logic [ADDR_W-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0]     w_rdata;

    logic                      w_div_start;
    logic                      w_div_busy;
    logic [NUM_W-1:0]          w_div_num;
    logic [NUM_W-1:0]          w_div_quot;

    // Handshakes; a capacity write wins over a request
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Decode of the current request against the stack shape
    assign w_ceff     = (r_cap == '0) ? CAP_W'(1) : r_cap;
    assign w_full     = (r_total == CNT_W'(DEPTH));
    assign w_idx_c    = CMP_W'(i_in.stack_index);
    assign w_sub_c    = CMP_W'(r_sub);
    assign w_total_c  = CMP_W'(r_total);
    assign w_ptr_c    = CMP_W'(r_ptr);
    assign w_idx_last = (r_sub != '0) && (w_idx_c == w_sub_c - 1'b1);
    assign w_idx_bad  = (w_idx_c >= w_sub_c);
    assign w_prod     = (CAP_W'(r_idx) + 1'b1) * w_ceff;

    // Width conversion of stored values
    assign w_push64 = i_in.push_value;
    assign w_rd_s   = w_rdata;
    assign w_rd64   = w_rd_s;

    // Entry memory ports
    assign w_we    = (w_in_xfer && (i_in.req_type == ssp_pkg::REQ_PUSH) && !w_full)
                     || (r_state == S_SH_WR);
    assign w_waddr = (r_state == S_SH_WR) ? r_ptr : r_total[ADDR_W-1:0];
    assign w_wdata = (r_state == S_SH_WR) ? w_rdata : w_push64[DATA_WIDTH-1:0];
    assign w_raddr = (r_state == S_SH_RD) ? (r_ptr + 1'b1) : r_ptr;

    ssp_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sub-stack count = ceil(total / capacity)
    assign w_div_start = (r_state == S_DIV_SET);
    assign w_div_num   = NUM_W'(r_total) + NUM_W'(w_ceff) - 1'b1;

    ssp_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_ceff),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    // Sequencer and stack state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap      <= ssp_pkg::CAP_RESET;
            r_total    <= '0;
            r_sub      <= '0;
            r_from_cfg <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_cfg_xfer) begin
                        r_cap      <= i_cfg_data;
                        r_from_cfg <= 1'b1;
                        r_state    <= S_DIV_SET;
                    end else if (w_in_xfer) begin
                        r_from_cfg <= 1'b0;
                        unique case (i_in.req_type)
                            ssp_pkg::REQ_PUSH: begin
                                if (w_full) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_total <= r_total + 1'b1;
                                    r_state <= S_DIV_SET;
                                end
                            end
                            ssp_pkg::REQ_POP, ssp_pkg::REQ_POP_AT: begin
                                if (i_in.req_type == ssp_pkg::REQ_POP_AT
                                    && !w_idx_last) begin
                                    r_state <= w_idx_bad ? S_DONE : S_MUL;
                                end else if (r_total == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    if (w_ptr_c + 1'b1 < w_total_c) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_total <= r_total - 1'b1;
                        r_state <= S_DIV_SET;
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (w_ptr_c + CMP_W'(2) < w_total_c) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_total <= r_total - 1'b1;
                        r_state <= S_DIV_SET;
                    end
                end
                S_DIV_SET: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_sub   <= w_div_quot[CNT_W-1:0];
                        r_state <= r_from_cfg ? S_IDLE : S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request payload: index, slot pointer, result value and status
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_idx    <= i_in.stack_index;
            r_ptr    <= ADDR_W'(r_total - 1'b1);
            r_val    <= '0;
            r_status <= ssp_pkg::ST_OK;
            unique case (i_in.req_type)
                ssp_pkg::REQ_PUSH: begin
                    if (w_full) begin
                        r_val    <= ssp_pkg::INT_MIN;
                        r_status <= ssp_pkg::ST_FULL;
                    end
                end
                ssp_pkg::REQ_POP, ssp_pkg::REQ_POP_AT: begin
                    if (i_in.req_type == ssp_pkg::REQ_POP_AT && !w_idx_last) begin
                        if (w_idx_bad) begin
                            r_val    <= ssp_pkg::INT_MIN;
                            r_status <= ssp_pkg::ST_BAD_INDEX;
                        end
                    end else if (r_total == '0) begin
                        r_val    <= ssp_pkg::INT_MIN;
                        r_status <= ssp_pkg::ST_UNDERFLOW;
                    end
                end
                default: begin
                    r_val <= '0;
                end
            endcase
        end else if (r_state == S_MUL) begin
            r_ptr <= ADDR_W'(w_prod - 1'b1);
        end else if (r_state == S_CAP) begin
            r_val <= w_rd64[VAL_W-1:0];
        end else if (r_state == S_SH_WR) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    // Output register; the next request may start while it waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.pop_value      <= r_val;
            r_out.status         <= r_status;
            r_out.element_count  <= ssp_pkg::COUNT_W'(r_total);
            r_out.substack_count <= ssp_pkg::COUNT_W'(r_sub);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_sub_matches_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_sub == '0) == (r_total == '0)))
        else $error("sub-stack count disagrees with empty stack");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD) |-> (w_ptr_c + 1'b1 < w_total_c))
        else $error("shift reads past the top");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside recompute");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_div_busy && r_state == S_IDLE))
        else $error("input ready while busy");

endmodule
